FILE: rtl/fnv5_pkg.sv
// Shared types, seeds, primes and lane functions for the five-lane FNV-style hash.
// Used by fnv5_lanes and fnv1a_five_lane_hash_120; no dependencies.
package fnv5_pkg;

  localparam int unsigned LaneW  = 32;
  localparam int unsigned NLanes = 5;

  localparam logic [LaneW-1:0] SEED_ZERO  = 32'h811C9DC5;
  localparam logic [LaneW-1:0] SEED_ONE   = 32'hA1B2C3D4;
  localparam logic [LaneW-1:0] SEED_TWO   = 32'h9E3779B9;
  localparam logic [LaneW-1:0] SEED_THREE = 32'hC2B2AE35;
  localparam logic [LaneW-1:0] SEED_FOUR  = 32'h165667B1;

  localparam logic [LaneW-1:0] PRIME_A = 32'd16777619;
  localparam logic [LaneW-1:0] PRIME_B = 32'd2166136261;
  localparam logic [LaneW-1:0] PRIME_C = 32'd1099511627;

  localparam int unsigned ROT_ONE   = 5;
  localparam int unsigned ROT_THREE = 7;

  typedef logic [NLanes-1:0][LaneW-1:0] lanes_t;

  typedef struct packed {
    logic [LaneW-1:0] m3;
    logic [LaneW-1:0] m2;
    logic [LaneW-1:0] m1;
    logic [LaneW-1:0] m0;
  } digest_t;

  typedef struct packed {
    logic absorb;
    logic reload;
  } lane_ctl_t;

  function automatic lanes_t seeds();
    lanes_t s;
    s[0] = SEED_ZERO;
    s[1] = SEED_ONE;
    s[2] = SEED_TWO;
    s[3] = SEED_THREE;
    s[4] = SEED_FOUR;
    return s;
  endfunction

  function automatic logic [LaneW-1:0] rotl(input logic [LaneW-1:0] x, input int unsigned r);
    return (x << r) | (x >> (LaneW - r));
  endfunction

  function automatic lanes_t absorb_byte(input lanes_t l, input logic [7:0] c);
    lanes_t           n;
    logic [LaneW-1:0] cw;
    cw   = {{(LaneW-8){1'b0}}, c};
    n[0] = (l[0] ^ cw) * PRIME_A;
    n[1] = rotl(l[1] ^ cw, ROT_ONE) * PRIME_B;
    n[2] = (l[2] ^ cw) * PRIME_C;
    n[3] = rotl(l[3] ^ cw, ROT_THREE) * PRIME_A;
    n[4] = (l[4] ^ cw) * PRIME_B;
    return n;
  endfunction

  function automatic digest_t mix(input lanes_t l);
    digest_t d;
    d.m0 = l[0] ^ l[1] ^ l[2] ^ l[3] ^ l[4];
    d.m1 = l[1] ^ d.m0;
    d.m2 = l[2] ^ l[3];
    d.m3 = l[3] ^ l[4];
    return d;
  endfunction

endpackage

FILE: rtl/fnv5_lanes.sv
// Lane state of the five-lane hash: absorbs one byte per absorb request and reloads seeds.
// Depends on fnv5_pkg.
module fnv5_lanes (
  input  logic                clk,
  input  logic                rst,
  input  fnv5_pkg::lane_ctl_t ctl,
  input  logic [7:0]          data_byte,
  output fnv5_pkg::digest_t   digest
);

  fnv5_pkg::lanes_t lanes;
  fnv5_pkg::lanes_t lanes_next;

  always_comb begin
    lanes_next = ctl.absorb ? fnv5_pkg::absorb_byte(lanes, data_byte) : lanes;
  end

  assign digest = fnv5_pkg::mix(lanes_next);

  always_ff @(posedge clk) begin
    if (rst || ctl.reload) begin
      lanes <= fnv5_pkg::seeds();
    end else begin
      lanes <= lanes_next;
    end
  end

endmodule

FILE: rtl/fnv1a_five_lane_hash_120.sv
// Top level of the five-lane FNV-style byte hash with a 120-bit digest.
// Depends on fnv5_pkg and fnv5_lanes.
//
// One byte request is taken every clock cycle unless the input stalls; each
// lane does one constant multiply per byte, so the lane update loops through
// one register. A request with tlast closes the message and yields two 64-bit
// digest words, word 0 then word 1 (tuser gives the word index, tlast marks
// word 1). The output side holds one digest being sent plus one waiting digest,
// so input stalls only when two finished digests are queued, for example with
// back-to-back one-byte messages.
module fnv1a_five_lane_hash_120 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_valid
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] digest_word
  output logic        m_tuser,   // [0] word_index
  output logic        m_tlast    // last_word
);

  fnv5_pkg::lane_ctl_t ctl;
  fnv5_pkg::digest_t   digest;

  fnv5_pkg::digest_t   act;
  fnv5_pkg::digest_t   act_next;
  logic                act_valid;
  logic                act_valid_next;
  logic                act_word;
  logic                act_word_next;
  fnv5_pkg::digest_t   pend;
  fnv5_pkg::digest_t   pend_next;
  logic                pend_valid;
  logic                pend_valid_next;

  logic accept;
  logic take;
  logic act_done;
  logic act_free;

  assign s_tready = !pend_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = accept && s_tlast;
  assign act_done = act_valid && m_tready && act_word;
  assign act_free = !act_valid || act_done;

  assign ctl.absorb = accept && s_tuser;
  assign ctl.reload = take;

  fnv5_lanes u_lanes (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .data_byte (s_tdata),
    .digest    (digest)
  );

  always_comb begin
    act_next        = act;
    act_valid_next  = act_valid;
    act_word_next   = act_word;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    if (act_free) begin
      if (pend_valid) begin
        act_next        = pend;
        act_valid_next  = 1'b1;
        act_word_next   = 1'b0;
        pend_valid_next = 1'b0;
      end else if (take) begin
        act_next       = digest;
        act_valid_next = 1'b1;
        act_word_next  = 1'b0;
      end else begin
        act_valid_next = 1'b0;
        act_word_next  = 1'b0;
      end
    end else begin
      if (m_tready) begin
        act_word_next = 1'b1;
      end
      if (take) begin
        pend_next       = digest;
        pend_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid  <= 1'b0;
      act_word   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      act_valid  <= act_valid_next;
      act_word   <= act_word_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    act  <= act_next;
    pend <= pend_next;
  end

  assign m_tvalid = act_valid;
  assign m_tuser  = act_word;
  assign m_tlast  = act_word;
  assign m_tdata  = act_word ? {8'd0, act.m3[23:0], act.m2} : {act.m1, act.m0};

  a_pend_needs_act: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> act_valid)
    else $error("waiting digest without an active digest");

  a_word_advance: assert property (@(posedge clk) disable iff (rst)
    act_valid && !act_word && m_tready |=> act_valid && act_word)
    else $error("word 0 taken but word 1 not presented");

  a_pend_promote: assert property (@(posedge clk) disable iff (rst)
    pend_valid && act_done |=> act_valid && !act_word && !pend_valid)
    else $error("waiting digest not promoted after word 1");

  a_word1_hold: assert property (@(posedge clk) disable iff (rst)
    act_valid && act_word && !m_tready |=> act_valid && act_word && $stable(act))
    else $error("stalled word 1 changed");

endmodule

FILE: verif/fnv5_digest_checker.sv
// Scoreboard for the five-lane FNV-style hash: tracks the lanes per accepted byte
// request and checks each digest word in order. Depends on fnv5_pkg.
module fnv5_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          mismatches,
  output int          words_due,
  output int          words_checked
);

  localparam logic WORD_LO = 1'b0;
  localparam logic WORD_HI = 1'b1;

  typedef struct {
    logic [63:0] word;
    logic        index;
    logic        last;
  } digest_word_t;

  fnv5_pkg::lanes_t lanes;
  digest_word_t     words_q[$];

  function automatic fnv5_pkg::lanes_t seed_lanes();
    fnv5_pkg::lanes_t s;
    s[0] = fnv5_pkg::SEED_ZERO;
    s[1] = fnv5_pkg::SEED_ONE;
    s[2] = fnv5_pkg::SEED_TWO;
    s[3] = fnv5_pkg::SEED_THREE;
    s[4] = fnv5_pkg::SEED_FOUR;
    return s;
  endfunction

  function automatic fnv5_pkg::lanes_t absorb_lanes(input fnv5_pkg::lanes_t l,
                                                    input logic [7:0] b);
    fnv5_pkg::lanes_t           n;
    logic [fnv5_pkg::LaneW-1:0] bw;
    logic [fnv5_pkg::LaneW-1:0] x1;
    logic [fnv5_pkg::LaneW-1:0] x3;
    bw   = {{(fnv5_pkg::LaneW-8){1'b0}}, b};
    x1   = l[1] ^ bw;
    x3   = l[3] ^ bw;
    n[0] = (l[0] ^ bw) * fnv5_pkg::PRIME_A;
    n[1] = {x1[fnv5_pkg::LaneW-1-fnv5_pkg::ROT_ONE:0],
            x1[fnv5_pkg::LaneW-1:fnv5_pkg::LaneW-fnv5_pkg::ROT_ONE]} * fnv5_pkg::PRIME_B;
    n[2] = (l[2] ^ bw) * fnv5_pkg::PRIME_C;
    n[3] = {x3[fnv5_pkg::LaneW-1-fnv5_pkg::ROT_THREE:0],
            x3[fnv5_pkg::LaneW-1:fnv5_pkg::LaneW-fnv5_pkg::ROT_THREE]} * fnv5_pkg::PRIME_A;
    n[4] = (l[4] ^ bw) * fnv5_pkg::PRIME_B;
    return n;
  endfunction

  always @(posedge clk) begin
    digest_word_t               got;
    digest_word_t               want;
    logic [fnv5_pkg::LaneW-1:0] m0;
    logic [fnv5_pkg::LaneW-1:0] m1;
    logic [fnv5_pkg::LaneW-1:0] m2;
    logic [fnv5_pkg::LaneW-1:0] m3;
    if (rst) begin
      lanes = seed_lanes();
      words_q.delete();
    end else begin
      // compare first: a word leaving now never belongs to a request taken now
      if (m_tvalid && m_tready) begin
        got = '{m_tdata, m_tuser, m_tlast};
        words_checked++;
        if (words_q.size() == 0) begin
          $display("%0t: unexpected digest word %h (index %b, last %b)",
                   $time, got.word, got.index, got.last);
          mismatches++;
        end else begin
          want = words_q.pop_front();
          if (got.word !== want.word) begin
            $display("%0t: digest word expected %h actual %h", $time, want.word, got.word);
            mismatches++;
          end
          if (got.index !== want.index) begin
            $display("%0t: word index expected %b actual %b", $time, want.index, got.index);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last word expected %b actual %b", $time, want.last, got.last);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser) lanes = absorb_lanes(lanes, s_tdata);
        if (s_tlast) begin
          m0 = lanes[0] ^ lanes[1] ^ lanes[2] ^ lanes[3] ^ lanes[4];
          m1 = lanes[1] ^ m0;
          m2 = lanes[2] ^ lanes[3];
          m3 = lanes[3] ^ lanes[4];
          words_q.push_back('{{m1, m0}, WORD_LO, 1'b0});
          words_q.push_back('{{8'h00, m3[23:0], m2}, WORD_HI, 1'b1});
          lanes = seed_lanes();
        end
      end
    end
    words_due = words_q.size();
  end

endmodule

FILE: verif/tb_fnv1a_five_lane_hash_120.sv
// Testbench top for fnv1a_five_lane_hash_120: drives byte requests and output stalls,
// then reports the verdict. Depends on the RTL and fnv5_digest_checker.
module tb_fnv1a_five_lane_hash_120;

  localparam int unsigned ITEM_GOAL   = 1300;
  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int          mismatches;
  int          words_due;
  int          words_checked;

  int unsigned src_idle = 19;
  int unsigned rcv_idle = 53;
  bit          hold_off = 1'b0;
  int unsigned bytes_sent;
  int unsigned msgs_sent;
  int unsigned items_sent;

  fnv1a_five_lane_hash_120 dut (.*);

  fnv5_digest_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // output side: random stalls, or one long hold when asked
  initial begin
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic valid, input logic eom);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 1'($urandom);
      s_tlast  <= 1'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= valid;
    s_tlast  <= eom;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (valid) bytes_sent++;
    if (eom) msgs_sent++;
    if (valid || eom) items_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    bit tail_on_byte;
    tail_on_byte = (len > 0) && ($urandom_range(2) != 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
      send_byte(8'($urandom), 1'b1, tail_on_byte && (i == len - 1));
    end
    if (!tail_on_byte) send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    bit          pressed;
    int unsigned len;
    pressed = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message, single extreme bytes
    send_byte(8'h3C, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    // ignored requests inside a message, closed by a bare end marker
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h55, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    // single set and single clear bit patterns, closed on a valid byte
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b1, 1'b0);
    send_byte(8'hFE, 1'b1, 1'b1);
    // two empty messages in a row, then a one-byte message
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hC3, 1'b1, 1'b1);

    while (items_sent < ITEM_GOAL) begin
      if (items_sent < ITEM_GOAL / 3) begin
        src_idle = 19;
        rcv_idle = 53;
      end else if (items_sent < 2 * ITEM_GOAL / 3) begin
        src_idle = 53;
        rcv_idle = 19;
      end else begin
        src_idle = 0;
        rcv_idle = 0;
        if (!pressed) begin
          pressed  = 1'b1;
          hold_off = 1'b1;
          for (int i = 0; i < 30; i++) send_byte(8'($urandom), 1'b1, 1'b1);
        end
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(12, 0);
      send_message(len);
    end
    s_tvalid <= 1'b0;

    while (words_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d bytes in %0d messages: empty, ignored-byte and end-marker cases.",
             bytes_sent, msgs_sent);
    $display("Checked %0d digest words under three stall mixes and a %0d-cycle output hold.",
             words_checked, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
